// ===== src/rss_pkg.sv =====
package rss_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed port widths
  localparam int REQ_W     = 3;
  localparam int ELEM_IO_W = 16;
  localparam int RANK_W    = 32;
  localparam int IDX_W     = 4;
  localparam int STS_W     = 2;
  localparam int SIZE_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_ERASE  = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_SUB    = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Broadcast control to every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic ers_en;
  } cell_ctl_t;

endpackage

// ===== src/rss_cell.sv =====
module rss_cell #(
  parameter int ELEM_WIDTH = rss_pkg::ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  rss_pkg::cell_ctl_t    ctl,
  input  logic                  occupied,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic                  left_lt,
  input  logic [ELEM_WIDTH-1:0] left_data,
  input  logic [ELEM_WIDTH-1:0] right_data,
  output logic [ELEM_WIDTH-1:0] data,
  output logic                  lt,
  output logic                  eq
);

  logic [ELEM_WIDTH-1:0] data_r, data_nxt;
  logic                  lt_r, eq_r;

  // Keep entries below the key; shift the rest toward the gap or away from it.
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en && !lt_r) begin
      data_nxt = left_lt ? key : left_data;
    end else if (ctl.ers_en && !lt_r) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cmp_en) begin
      lt_r <= occupied && (data_r < key);
      eq_r <= occupied && (data_r == key);
    end
  end

  assign data = data_r;
  assign lt   = lt_r;
  assign eq   = eq_r;

endmodule

// ===== src/ranked_sorted_set.sv =====
// ranked_sorted_set: sorted set of unique elements with a signed running rank.
// out_valid rises once the item has passed the compare and update states.
// A new item is taken only in idle, after the last has left the update stage; the
// compare and shift passes run in separate states, and a stalled result holds update.
// Reset (rst_n low, synchronous): set empty, rank zero, no result pending;
// the cell contents are not cleared.
module ranked_sorted_set #(
  parameter int CAPACITY   = rss_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = rss_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rss_pkg::REQ_W-1:0]              in_req_type,
  input  logic [rss_pkg::ELEM_IO_W-1:0]          in_element,
  input  logic signed [rss_pkg::RANK_W-1:0]      in_rank_delta,
  input  logic [rss_pkg::IDX_W-1:0]              in_read_index,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rss_pkg::STS_W-1:0]              out_status,
  output logic [rss_pkg::ELEM_IO_W-1:0]          out_read_element,
  output logic [rss_pkg::SIZE_W-1:0]             out_set_size,
  output logic signed [rss_pkg::RANK_W-1:0]      out_rank_value,
  output logic                                   out_nonzero
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IXW   = rss_pkg::IDX_W + CNT_W;

  rss_pkg::state_t state_r, state_nxt;

  // Captured request
  rss_pkg::req_t                       req_type_r;
  logic [ELEM_WIDTH-1:0]               req_elem_r;
  logic signed [rss_pkg::RANK_W-1:0]   req_delta_r;
  logic [rss_pkg::IDX_W-1:0]           req_idx_r;

  // Architectural state beside the cell row
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic signed [rss_pkg::RANK_W-1:0]   rank_r, rank_nxt;

  // Result register
  logic                                out_valid_r;
  rss_pkg::status_t                    sts_r, sts_nxt;
  logic [ELEM_WIDTH-1:0]               rd_r, rd_nxt;
  logic [CNT_W-1:0]                    size_r;
  logic signed [rss_pkg::RANK_W-1:0]   rank_out_r;
  logic                                nonzero_r;

  // Cell row
  rss_pkg::cell_ctl_t                  ctl;
  logic [ELEM_WIDTH-1:0]               cell_data [CAPACITY];
  logic [CAPACITY-1:0]                 cell_lt;
  logic [CAPACITY-1:0]                 cell_eq;
  logic [CAPACITY-1:0]                 cell_occ;

  logic in_fire, upd_go, found, full, idx_ok, ins_ok, ers_ok;

  assign in_fire = in_valid && in_ready;
  // Update only when the result register can take the outcome
  assign upd_go  = (state_r == rss_pkg::S_UPD) && (!out_valid_r || out_ready);
  assign found   = |cell_eq;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign idx_ok  = IXW'(req_idx_r) < IXW'(count_r);

  // Cell i holds a live element when it sits below the fill count.
  // Each cell looks at its left neighbor on insert and its right neighbor on erase;
  // the ends of the row see a "less than" on the left and their own data on the right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_lt;
    logic [ELEM_WIDTH-1:0] l_data;
    logic [ELEM_WIDTH-1:0] r_data;

    assign cell_occ[i] = count_r > CNT_W'(i);

    if (i == 0) begin : g_first
      assign l_lt   = 1'b1;
      assign l_data = req_elem_r;
    end else begin : g_mid
      assign l_lt   = cell_lt[i-1];
      assign l_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = cell_data[i];
    end else begin : g_body
      assign r_data = cell_data[i+1];
    end

    rss_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (cell_occ[i]),
      .key        (req_elem_r),
      .left_lt    (l_lt),
      .left_data  (l_data),
      .right_data (r_data),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  // Decide the outcome from the compare flags latched in the cells
  always_comb begin
    sts_nxt   = rss_pkg::STS_MISS;
    rd_nxt    = '0;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    ins_ok    = 1'b0;
    ers_ok    = 1'b0;
    unique case (req_type_r)
      rss_pkg::REQ_INSERT: begin
        if (found) begin
          sts_nxt = rss_pkg::STS_MISS;
        end else if (full) begin
          sts_nxt = rss_pkg::STS_FULL;
        end else begin
          sts_nxt   = rss_pkg::STS_DONE;
          ins_ok    = 1'b1;
          count_nxt = count_r + 1'b1;
          rank_nxt  = rank_r + req_delta_r;
        end
      end
      rss_pkg::REQ_ERASE: begin
        if (found) begin
          sts_nxt   = rss_pkg::STS_DONE;
          ers_ok    = 1'b1;
          count_nxt = count_r - 1'b1;
          rank_nxt  = rank_r - req_delta_r;
        end
      end
      rss_pkg::REQ_ADD: begin
        sts_nxt  = rss_pkg::STS_DONE;
        rank_nxt = rank_r + req_delta_r;
      end
      rss_pkg::REQ_SUB: begin
        sts_nxt  = rss_pkg::STS_DONE;
        rank_nxt = rank_r - req_delta_r;
      end
      rss_pkg::REQ_READ: begin
        if (idx_ok) begin
          sts_nxt = rss_pkg::STS_DONE;
          for (int i = 0; i < CAPACITY; i++) begin
            if (IXW'(req_idx_r) == IXW'(i)) begin
              rd_nxt = cell_data[i];
            end
          end
        end
      end
      default: begin
        sts_nxt = rss_pkg::STS_MISS;
      end
    endcase
  end

  // Sequencer: idle -> compare -> update
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    ctl.cmp_en = 1'b0;
    ctl.ins_en = 1'b0;
    ctl.ers_en = 1'b0;
    unique case (state_r)
      rss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = rss_pkg::S_CMP;
        end
      end
      rss_pkg::S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = rss_pkg::S_UPD;
      end
      rss_pkg::S_UPD: begin
        ctl.ins_en = upd_go && ins_ok;
        ctl.ers_en = upd_go && ers_ok;
        if (upd_go) begin
          state_nxt = rss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rss_pkg::S_IDLE;
      count_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        count_r     <= count_nxt;
        rank_r      <= rank_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r  <= rss_pkg::req_t'(in_req_type);
      req_elem_r  <= ELEM_WIDTH'(in_element);
      req_delta_r <= in_rank_delta;
      req_idx_r   <= in_read_index;
    end
    if (upd_go) begin
      sts_r      <= sts_nxt;
      rd_r       <= rd_nxt;
      size_r     <= count_nxt;
      rank_out_r <= rank_nxt;
      nonzero_r  <= (rank_nxt != '0) || (count_nxt != '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = sts_r;
  assign out_read_element = rss_pkg::ELEM_IO_W'(rd_r);
  assign out_set_size     = rss_pkg::SIZE_W'(size_r);
  assign out_rank_value   = rank_out_r;
  assign out_nonzero      = nonzero_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins_en && ctl.ers_en))
    else $error("insert and erase shift together");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the set");

  a_ers_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ers_en |=> count_r == CNT_W'($past(count_r) - 1'b1))
    else $error("erase did not shrink the set");

  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_chk_order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r > CNT_W'(i + 1)) |-> (cell_data[i] < cell_data[i+1]))
      else $error("live cells out of order");
  end
`endif

endmodule

// ===== sim/ranked_sorted_set_test.sv =====
`timescale 1ns / 100ps
module ranked_sorted_set_test;
  import rss_pkg::*;

  localparam int                CAP           = CAPACITY_DEF;
  localparam logic [REQ_W-1:0]  REQ_CODE_MAX  = '1;
  localparam logic [RANK_W-1:0] RANK_MAX      = 32'h7fff_ffff;
  localparam logic [RANK_W-1:0] RANK_MIN      = 32'h8000_0000;
  localparam logic [RANK_W-1:0] RANK_ONE      = 32'd1;
  localparam int                SETTLE_CYCLES = 8;

  // One result as the block should produce it.
  typedef struct packed {
    status_t               status;
    logic [ELEM_IO_W-1:0]  read_element;
    logic [SIZE_W-1:0]     set_size;
    logic [RANK_W-1:0]     rank_value;
    logic                  nonzero;
  } set_result_t;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        in_valid      = 1'b0;
  logic [REQ_W-1:0]            in_req_type   = '0;
  logic [ELEM_IO_W-1:0]        in_element    = '0;
  logic signed [RANK_W-1:0]    in_rank_delta = '0;
  logic [IDX_W-1:0]            in_read_index = '0;
  logic                        out_ready     = 1'b0;
  logic                        in_ready;
  logic                        out_valid;
  logic [STS_W-1:0]            out_status;
  logic [ELEM_IO_W-1:0]        out_read_element;
  logic [SIZE_W-1:0]           out_set_size;
  logic signed [RANK_W-1:0]    out_rank_value;
  logic                        out_nonzero;

  ranked_sorted_set dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_element       (in_element),
    .in_rank_delta    (in_rank_delta),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_read_element (out_read_element),
    .out_set_size     (out_set_size),
    .out_rank_value   (out_rank_value),
    .out_nonzero      (out_nonzero)
  );

  // Shadow copy of the set: ascending elements, their count and the rank.
  logic [ELEM_IO_W-1:0] shadow_elems [CAP];
  int                   shadow_count = 0;
  logic [RANK_W-1:0]    shadow_rank  = '0;

  set_result_t pending_results [$];
  int          fail_count = 0;
  int          burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one request to the shadow set and return the result it must give.
  function automatic set_result_t apply_request(input logic [REQ_W-1:0] req,
                                                input logic [ELEM_IO_W-1:0] elem,
                                                input logic [RANK_W-1:0] delta,
                                                input logic [IDX_W-1:0] idx);
    set_result_t res;
    int          pos;
    int          i;
    bit          present;
    res.status       = STS_MISS;
    res.read_element = '0;
    // Lower bound: first slot not below the element.
    pos = 0;
    while (pos < shadow_count && shadow_elems[pos] < elem) pos++;
    present = (pos < shadow_count) && (shadow_elems[pos] == elem);
    case (req)
      REQ_INSERT: begin
        if (present) begin
          res.status = STS_MISS;
        end else if (shadow_count >= CAP) begin
          res.status = STS_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[pos] = elem;
          shadow_count++;
          shadow_rank += delta;
          res.status = STS_DONE;
        end
      end
      REQ_ERASE: begin
        if (present) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_count--;
          shadow_rank -= delta;
          res.status = STS_DONE;
        end
      end
      REQ_ADD: begin
        shadow_rank += delta;
        res.status = STS_DONE;
      end
      REQ_SUB: begin
        shadow_rank -= delta;
        res.status = STS_DONE;
      end
      REQ_READ: begin
        if (idx < shadow_count) begin
          res.read_element = shadow_elems[idx];
          res.status       = STS_DONE;
        end
      end
      default: ;
    endcase
    res.set_size   = shadow_count[SIZE_W-1:0];
    res.rank_value = shadow_rank;
    res.nonzero    = (shadow_rank != '0) || (shadow_count != 0);
    return res;
  endfunction

  function automatic bit set_holds(input logic [ELEM_IO_W-1:0] elem);
    int i;
    for (i = 0; i < shadow_count; i++) if (shadow_elems[i] == elem) return 1'b1;
    return 1'b0;
  endfunction

  // A small pool for some picks so duplicates and hits are common; some extremes; the rest random.
  function automatic logic [ELEM_IO_W-1:0] pick_element();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 3) return ELEM_IO_W'($urandom_range(0, 23));
    if (sel == 3) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return ELEM_IO_W'($urandom);
  endfunction

  function automatic logic [RANK_W-1:0] pick_delta();
    case ($urandom_range(0, 11))
      0: return RANK_MAX;
      1: return RANK_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Drive one item and hold it until accepted; bursts with random gaps between.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [ELEM_IO_W-1:0] elem,
                           input logic [RANK_W-1:0] delta, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_element    <= elem;
    in_rank_delta <= delta;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(req, elem, delta, idx));
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Edge values, each request type, wrap of the rank, misses, unknown codes.
  task automatic test_directed();
    logic [REQ_W-1:0] code;
    send_item(REQ_READ, pick_element(), pick_delta(), '0);         // read on empty set
    send_item(REQ_ERASE, 16'd5, 32'd7, '1);                          // erase of absent item
    send_item(REQ_INSERT, '0, RANK_MAX, '1);
    send_item(REQ_INSERT, '1, RANK_ONE, '0);                         // rank wraps negative
    send_item(REQ_INSERT, '0, RANK_MAX, '0);                         // duplicate
    send_item(REQ_INSERT, 16'h8000, '0, '1);
    send_item(REQ_READ, '0, '1, 4'd0);
    send_item(REQ_READ, '1, '0, 4'd1);
    send_item(REQ_READ, '0, '0, 4'd2);
    send_item(REQ_READ, '0, '0, 4'd3);                               // one past the end
    send_item(REQ_READ, '0, '0, '1);
    send_item(REQ_ADD, '1, RANK_MIN, '1);
    send_item(REQ_SUB, '0, RANK_MAX, '0);
    send_item(REQ_SUB, '1, RANK_MIN, '0);
    for (int c = int'(REQ_READ) + 1; c <= int'(REQ_CODE_MAX); c++) begin
      code = REQ_W'(c);
      send_item(code, '1, '1, '1);
    end
    send_item(REQ_ERASE, 16'h8000, '1, '0);
    send_item(REQ_ERASE, '1, RANK_MIN, '0);
    send_item(REQ_ERASE, '1, RANK_MIN, '0);                          // already gone
    send_item(REQ_ERASE, '0, '0, '0);
    // Set is empty now; cancel the rank so nonzero must drop.
    send_item(REQ_SUB, '0, shadow_rank, '0);
    send_item(REQ_READ, '0, '0, '0);
  endtask

  // Empty the set in random order, then zero the rank.
  task automatic test_clear_all();
    while (shadow_count > 0)
      send_item(REQ_ERASE, shadow_elems[$urandom_range(0, shadow_count - 1)], pick_delta(),
                IDX_W'($urandom));
    send_item(REQ_SUB, pick_element(), shadow_rank, IDX_W'($urandom));
    send_item(REQ_READ, pick_element(), pick_delta(), IDX_W'($urandom));
  endtask

  // Fill to capacity, hit full and duplicate-when-full, read every slot, drain.
  task automatic test_full_store();
    logic [ELEM_IO_W-1:0] extra;
    while (shadow_count < CAP)
      send_item(REQ_INSERT, ELEM_IO_W'($urandom), pick_delta(), IDX_W'($urandom));
    do extra = pick_element(); while (set_holds(extra));
    send_item(REQ_INSERT, extra, pick_delta(), IDX_W'($urandom));
    send_item(REQ_INSERT, shadow_elems[$urandom_range(0, CAP - 1)], pick_delta(), '0);
    for (int i = 0; i < CAP; i++)
      send_item(REQ_READ, pick_element(), pick_delta(), IDX_W'(i));
    test_clear_all();
  endtask

  // Random mix weighted toward inserts so the set fills up and empties again.
  task automatic test_random_mix(input int count);
    int                   sel;
    logic [REQ_W-1:0]     req;
    logic [ELEM_IO_W-1:0] elem;
    logic [IDX_W-1:0]     idx;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      elem = pick_element();
      idx  = IDX_W'($urandom);
      if (sel < 35) begin
        req = REQ_INSERT;
      end else if (sel < 60) begin
        req = REQ_ERASE;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
          elem = shadow_elems[$urandom_range(0, shadow_count - 1)];
      end else if (sel < 70) begin
        req = REQ_ADD;
      end else if (sel < 78) begin
        req = REQ_SUB;
      end else if (sel < 96) begin
        req = REQ_READ;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
          idx = IDX_W'($urandom_range(0, shadow_count - 1));
      end else begin
        req = REQ_W'($urandom_range(int'(REQ_READ) + 1, int'(REQ_CODE_MAX)));
      end
      send_item(req, elem, pick_delta(), idx);
    end
  endtask

  // Receiver stalls: the pattern switches at random among four modes.
  int stall_left = 0;
  int stall_mode = 0;
  int cycle_ctr  = 0;
  always @(posedge clk) begin
    cycle_ctr++;
    if (cycle_ctr % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      case (stall_mode)
        1: stall_left = $urandom_range(0, 1);
        2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(2, 12);
        3: stall_left = $urandom_range(0, 3);
        default: ;
      endcase
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Match each accepted result against the oldest outstanding expectation.
  always @(posedge clk) begin
    set_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no outstanding item: status %0d size %0d",
               out_status, out_set_size);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", longint'(want.status), longint'(out_status));
        check_field("read_element", longint'(want.read_element), longint'(out_read_element));
        check_field("set_size", longint'(want.set_size), longint'(out_set_size));
        check_field("rank_value", longint'($signed(want.rank_value)),
                    longint'(out_rank_value));
        check_field("nonzero", longint'(want.nonzero), longint'(out_nonzero));
      end
    end
  end

  initial begin
    apply_reset();
    test_directed();
    test_clear_all();
    test_full_store();
    // Random rounds; pause for a full drain between them.
    for (int r = 0; r < 6; r++) begin
      test_random_mix(300);
      wait_idle();
      if (r % 2 == 1) test_clear_all();
    end
    test_full_store();
    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rss_pkg.sv
src/rss_cell.sv
src/ranked_sorted_set.sv
sim/ranked_sorted_set_test.sv
